// File: rtl/acc_rep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_rep_pkg
// Shared types, codes and constants for the accelerometer repetition counter.
// ----------------------------------------------------------------------------
package acc_rep_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  // Smoother: (26214*f + 6554*az + 16384) >> 15
  localparam int COEF_OLD   = 26214;
  localparam int COEF_NEW   = 6554;
  localparam int ROUND_BIAS = 16384;
  localparam int FILT_SHIFT = 15;
  localparam int FILT_RESET = 4096;   // 1.0 g in Q3.12

  // Thresholds in Q3.12
  localparam int TH_BELOW_090 = 3687;
  localparam int TH_ABOVE_115 = 4710;
  localparam int TH_ABOVE_105 = 4300;
  localparam int TH_ABOVE_110 = 4505;
  localparam int TH_BELOW_095 = 3892;

  // Exercise modes
  localparam logic [1:0] MODE_PRESS    = 2'd0;
  localparam logic [1:0] MODE_CURL     = 2'd1;
  localparam logic [1:0] MODE_PULLDOWN = 2'd2;

  // Motion phase codes on the result channel
  localparam logic [1:0] MP_IDLE = 2'd0;
  localparam logic [1:0] MP_DOWN = 2'd1;
  localparam logic [1:0] MP_UP   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REFR = 2'd1;

  localparam logic [15:0] REFR_RESET = 16'd800;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DOWN = 3'b010,
    PH_UP   = 3'b100
  } phase_t;

  // Per-item control that travels alongside the filtered value
  typedef struct packed {
    logic [31:0] now_ms;
    logic        count_enable;
    logic        clear_count;
  } tick_ctl_t;

  function automatic logic [1:0] phase_code(phase_t p);
    logic [1:0] c;
    unique case (p)
      PH_IDLE: c = MP_IDLE;
      PH_DOWN: c = MP_DOWN;
      PH_UP:   c = MP_UP;
      default: c = MP_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/acc_rep_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_rep_if
// Valid/ready channels: tick items in, results out, configuration writes.
// ----------------------------------------------------------------------------
interface acc_in_if #(
  parameter int SAMPLE_BITS = acc_rep_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          has_sample;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic [31:0]                   now_ms;
  logic                          count_enable;
  logic                          clear_count;

  modport source (output valid, has_sample, accel_z, now_ms, count_enable, clear_count,
                  input ready);
  modport sink   (input valid, has_sample, accel_z, now_ms, count_enable, clear_count,
                  output ready);
endinterface

interface acc_out_if #(
  parameter int SAMPLE_BITS = acc_rep_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [15:0]                   rep_total;
  logic [1:0]                    motion_phase;
  logic signed [SAMPLE_BITS-1:0] smoothed_z;
  logic                          rep_event;

  modport source (output valid, rep_total, motion_phase, smoothed_z, rep_event,
                  input ready);
  modport sink   (input valid, rep_total, motion_phase, smoothed_z, rep_event,
                  output ready);
endinterface

interface acc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [acc_rep_pkg::CFG_IDX_W-1:0]     index;
  logic [acc_rep_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/accel_repetition_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_repetition_counter
// Smoothed Z acceleration, exercise phase tracking and repetition counting.
// ----------------------------------------------------------------------------
// Pipeline: the input register loads on the accept edge, then the filter
//   state register, then the result register, which presents the result.
// Throughput: one item per cycle unless out_ch.ready stalls; the filter
//   and phase machine each close their state loop within a single stage.
// Reset (synchronous, rst_n low): pipeline empty, filter 1.0 g, phase idle,
//   count 0, last repetition time 0, mode press, refractory 800 ms.
// ----------------------------------------------------------------------------
module accel_repetition_counter #(
  parameter int SAMPLE_BITS = acc_rep_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  acc_in_if.sink      in_ch,
  acc_out_if.source   out_ch,
  acc_cfg_if.sink     cfg_ch
);
  import acc_rep_pkg::*;

  // Configuration
  logic [1:0]  mode_r;
  logic [15:0] refr_r;

  // Input stage
  logic                          a_vld_r;
  logic                          a_has_r;
  logic signed [SAMPLE_BITS-1:0] a_az_r;
  tick_ctl_t                     a_ctl_r;

  // Filter stage (value lives in the filter)
  logic                          b_vld_r;
  tick_ctl_t                     b_ctl_r;
  logic signed [SAMPLE_BITS-1:0] filt_z;

  // Result stage
  logic o_vld_r;

  logic in_acc, a_adv, b_adv, a_free, b_free, o_free;

  assign o_free = !o_vld_r || out_ch.ready;
  assign b_adv  = b_vld_r && o_free;
  assign b_free = !b_vld_r || o_free;
  assign a_adv  = a_vld_r && b_free;
  assign a_free = !a_vld_r || b_free;
  assign in_ch.ready = a_free;
  assign in_acc = in_ch.valid && a_free;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PRESS;
      refr_r <= REFR_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_IDX_MODE) begin
        mode_r <= cfg_ch.data[1:0];
      end else if (cfg_ch.index == CFG_IDX_REFR) begin
        refr_r <= cfg_ch.data[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_vld_r <= in_ch.valid;
      end
      if (b_free) begin
        b_vld_r <= a_vld_r;
      end
      if (o_free) begin
        o_vld_r <= b_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_has_r              <= in_ch.has_sample;
      a_az_r               <= in_ch.accel_z;
      a_ctl_r.now_ms       <= in_ch.now_ms;
      a_ctl_r.count_enable <= in_ch.count_enable;
      a_ctl_r.clear_count  <= in_ch.clear_count;
    end
    if (a_adv) begin
      b_ctl_r <= a_ctl_r;
    end
  end

  acc_rep_filter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (a_adv),
    .has_sample (a_has_r),
    .accel_z    (a_az_r),
    .filt_z     (filt_z)
  );

  acc_rep_phase #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_phase (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (b_adv),
    .filt_z        (filt_z),
    .ctl           (b_ctl_r),
    .exercise_mode (mode_r),
    .refractory_ms (refr_r),
    .rep_total     (out_ch.rep_total),
    .motion_phase  (out_ch.motion_phase),
    .smoothed_z    (out_ch.smoothed_z),
    .rep_event     (out_ch.rep_event)
  );

  assign out_ch.valid = o_vld_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !a_vld_r |-> in_ch.ready)
    else $error("input stalled with an empty input stage");

  a_item_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && b_free |=> b_vld_r)
    else $error("item lost between input and filter stage");

  a_result_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && o_free |=> o_vld_r)
    else $error("item lost between filter and result stage");

endmodule

// File: rtl/acc_rep_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_rep_filter
// Exponential smoother on Z acceleration; the state register is also the
// filtered value presented to the phase stage.
// ----------------------------------------------------------------------------
module acc_rep_filter #(
  parameter int SAMPLE_BITS = acc_rep_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          has_sample,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output logic signed [SAMPLE_BITS-1:0] filt_z
);
  import acc_rep_pkg::*;

  localparam int PW = SAMPLE_BITS + 17;
  localparam longint SMAX_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SMIN_L = -SMAX_L - 1;
  localparam logic signed [PW-1:0] SMAX = PW'(SMAX_L);
  localparam logic signed [PW-1:0] SMIN = PW'(SMIN_L);
  localparam logic signed [SAMPLE_BITS-1:0] F_RST =
    SAMPLE_BITS'((longint'(FILT_RESET) > SMAX_L) ? SMAX_L : longint'(FILT_RESET));

  logic signed [SAMPLE_BITS-1:0] filt_r, filt_nxt;
  logic signed [PW-1:0]          prod_old, prod_new, acc, shifted;

  always_comb begin
    prod_old = PW'(filt_r) * PW'(COEF_OLD);
    prod_new = PW'(accel_z) * PW'(COEF_NEW);
    acc      = prod_old + prod_new + PW'(ROUND_BIAS);
    shifted  = acc >>> FILT_SHIFT;   // arithmetic shift = floor
    if (!has_sample) begin
      filt_nxt = filt_r;
    end else if (shifted > SMAX) begin
      filt_nxt = SMAX[SAMPLE_BITS-1:0];
    end else if (shifted < SMIN) begin
      filt_nxt = SMIN[SAMPLE_BITS-1:0];
    end else begin
      filt_nxt = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= F_RST;
    end else if (load) begin
      filt_r <= filt_nxt;
    end
  end

  assign filt_z = filt_r;

  a_hold_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    load && !has_sample |=> $stable(filt_r))
    else $error("filter moved on an item without a sample");

endmodule

// File: rtl/acc_rep_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_rep_phase
// Per-exercise hysteresis phase machine, refractory gate, saturating count
// and the result register.
// ----------------------------------------------------------------------------
module acc_rep_phase #(
  parameter int SAMPLE_BITS = acc_rep_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] filt_z,
  input  acc_rep_pkg::tick_ctl_t        ctl,
  input  logic [1:0]                    exercise_mode,
  input  logic [15:0]                   refractory_ms,
  output logic [15:0]                   rep_total,
  output logic [1:0]                    motion_phase,
  output logic signed [SAMPLE_BITS-1:0] smoothed_z,
  output logic                          rep_event
);
  import acc_rep_pkg::*;

  phase_t                        phase_r, phase_nxt;
  logic [15:0]                   count_r, count_nxt;
  logic [31:0]                   last_r, last_nxt;
  logic                          evt_r;
  logic signed [SAMPLE_BITS-1:0] smz_r;
  logic signed [31:0]            k;
  logic [31:0]                   elapsed;
  logic                          gap_ok, hit;

  always_comb begin
    k       = 32'(filt_z);
    elapsed = ctl.now_ms - last_r;   // wraps modulo 2^32
    gap_ok  = elapsed > {16'd0, refractory_ms};
    hit     = 1'b0;
    phase_nxt = phase_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    if (ctl.clear_count) begin
      count_nxt = '0;
      phase_nxt = PH_IDLE;
    end else if (ctl.count_enable) begin
      unique case (exercise_mode)
        MODE_PRESS: begin
          if (phase_r == PH_IDLE && k < TH_BELOW_090) begin
            phase_nxt = PH_DOWN;
          end else if (phase_r == PH_DOWN && k > TH_ABOVE_115) begin
            phase_nxt = PH_UP;
          end else if (phase_r == PH_UP && k > TH_ABOVE_105 && gap_ok) begin
            hit = 1'b1;
          end
        end
        MODE_CURL: begin
          if (phase_r == PH_IDLE && k > TH_ABOVE_110) begin
            phase_nxt = PH_UP;
          end else if (phase_r == PH_UP && k < TH_BELOW_090 && gap_ok) begin
            hit = 1'b1;
          end
        end
        MODE_PULLDOWN: begin
          if (phase_r == PH_IDLE && k < TH_BELOW_095) begin
            phase_nxt = PH_DOWN;
          end else if (phase_r == PH_DOWN && k > TH_ABOVE_110 && gap_ok) begin
            hit = 1'b1;
          end
        end
        default: ;   // unused mode: machine frozen
      endcase
    end
    if (hit) begin
      count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;
      last_nxt  = ctl.now_ms;
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      last_r  <= '0;
      evt_r   <= 1'b0;
    end else if (load) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      evt_r   <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      smz_r <= filt_z;
    end
  end

  assign rep_total    = count_r;
  assign motion_phase = phase_code(phase_r);
  assign smoothed_z   = smz_r;
  assign rep_event    = evt_r;

  a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
    evt_r |-> (count_r != 16'd0 && phase_r == PH_IDLE))
    else $error("repetition flagged without count or idle phase");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    load && !ctl.clear_count |=> count_r >= $past(count_r))
    else $error("count fell without a clear");

  a_last_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    load && !hit |=> $stable(last_r))
    else $error("last repetition time moved without a repetition");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accelerometer repetition counter. Tick items
// are queued for a clocked driver and predicted as they are accepted. A
// clocked monitor compares each result with the oldest prediction. Stimulus
// runs through directed ticks, random well-formed motion in every exercise
// mode under several idle and stall patterns, and a short run of curl
// repetitions.
// ----------------------------------------------------------------------------
module tb_top;
  import acc_rep_pkg::*;

  localparam int SB             = SAMPLE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_SEGS         = 8;
  localparam int TICKS_PER_SEG  = 200;
  localparam int PENDING_MAX    = 64;
  localparam int TAIL_REPS      = 3;
  localparam int MAX_REPORTS    = 10;

  localparam logic [1:0]            MODE_UNUSED = 2'd3;
  localparam logic signed [SB-1:0]  AZ_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]  AZ_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam longint                Z_MAX  = (longint'(1) <<< (SB-1)) - 1;
  localparam longint                Z_MIN  = -Z_MAX - 1;

  typedef struct packed {
    logic                 has_sample;
    logic signed [SB-1:0] accel_z;
    logic [31:0]          now_ms;
    logic                 count_enable;
    logic                 clear_count;
  } tick_t;

  typedef struct packed {
    logic [15:0]          rep_total;
    logic [1:0]           motion_phase;
    logic signed [SB-1:0] smoothed_z;
    logic                 rep_event;
  } rep_res_t;

  typedef enum int {LV_HIGH, LV_LOW, LV_HOVER, LV_NOISE} accel_lvl_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  acc_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  acc_out_if #(.SAMPLE_BITS(SB)) out_ch ();
  acc_cfg_if                     cfg_ch ();

  accel_repetition_counter #(.SAMPLE_BITS(SB)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Everything the bench drives, known from time zero
  tick_t                 drv_tick      = '0;
  logic                  drv_in_valid  = 1'b0;
  logic                  drv_out_ready = 1'b0;
  logic                  drv_cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  drv_cfg_index = '0;
  logic [CFG_DATA_W-1:0] drv_cfg_data  = '0;

  assign in_ch.valid        = drv_in_valid;
  assign in_ch.has_sample   = drv_tick.has_sample;
  assign in_ch.accel_z      = drv_tick.accel_z;
  assign in_ch.now_ms       = drv_tick.now_ms;
  assign in_ch.count_enable = drv_tick.count_enable;
  assign in_ch.clear_count  = drv_tick.clear_count;
  assign out_ch.ready       = drv_out_ready;
  assign cfg_ch.valid       = drv_cfg_valid;
  assign cfg_ch.index       = drv_cfg_index;
  assign cfg_ch.data        = drv_cfg_data;

  // Predictor state and configuration
  logic [1:0]           cur_mode    = MODE_PRESS;
  logic [15:0]          min_gap_ms  = REFR_RESET;
  logic signed [SB-1:0] filt_z      = SB'(FILT_RESET);
  logic [1:0]           motion      = MP_IDLE;
  logic [15:0]          reps        = '0;
  logic [31:0]          last_rep_ms = '0;

  tick_t    tick_q[$];
  rep_res_t rep_expect_q[$];
  tick_t    tick_cur;
  logic     tick_busy = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int n_checked      = 0;
  int n_events       = 0;
  int idle_cycles    = 0;

  logic [31:0] t_clock = 32'h0000_2000;
  accel_lvl_t  lvl     = LV_HOVER;
  int          lvl_run = 0;

  function automatic rep_res_t predict_rep_tick(tick_t t);
    longint   acc;
    int       kz;
    logic     gap_ok;
    logic     fired;
    rep_res_t r;
    fired = 1'b0;
    if (t.has_sample) begin
      acc = longint'(COEF_OLD) * longint'(filt_z)
          + longint'(COEF_NEW) * longint'($signed(t.accel_z)) + longint'(ROUND_BIAS);
      acc = acc >>> FILT_SHIFT;
      if (acc > Z_MAX) acc = Z_MAX;
      else if (acc < Z_MIN) acc = Z_MIN;
      filt_z = SB'(acc);
    end
    kz = int'(filt_z);
    gap_ok = (t.now_ms - last_rep_ms) > {16'd0, min_gap_ms};
    if (t.clear_count) begin
      reps   = '0;
      motion = MP_IDLE;
    end else if (t.count_enable) begin
      case (cur_mode)
        MODE_PRESS: begin
          if (motion == MP_IDLE && kz < TH_BELOW_090) motion = MP_DOWN;
          else if (motion == MP_DOWN && kz > TH_ABOVE_115) motion = MP_UP;
          else if (motion == MP_UP && kz > TH_ABOVE_105 && gap_ok) fired = 1'b1;
        end
        MODE_CURL: begin
          if (motion == MP_IDLE && kz > TH_ABOVE_110) motion = MP_UP;
          else if (motion == MP_UP && kz < TH_BELOW_090 && gap_ok) fired = 1'b1;
        end
        MODE_PULLDOWN: begin
          if (motion == MP_IDLE && kz < TH_BELOW_095) motion = MP_DOWN;
          else if (motion == MP_DOWN && kz > TH_ABOVE_110 && gap_ok) fired = 1'b1;
        end
        default: ;
      endcase
      if (fired) begin
        if (reps != COUNT_MAX) reps++;
        last_rep_ms = t.now_ms;
        motion      = MP_IDLE;
        n_events++;
      end
    end
    r.rep_total    = reps;
    r.motion_phase = motion;
    r.smoothed_z   = filt_z;
    r.rep_event    = fired;
    return r;
  endfunction

  // Driver: one item held on the bus until it is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!tick_busy && tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        tick_cur  = tick_q.pop_front();
        tick_busy = 1'b1;
        drv_tick <= tick_cur;
      end
      drv_in_valid <= tick_busy;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rep_expect_q.push_back(predict_rep_tick(tick_cur));
      tick_busy = 1'b0;
    end
  end

  // Monitor
  always @(negedge clk) begin
    drv_out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_mon
    rep_res_t got;
    rep_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rep_total    = out_ch.rep_total;
      got.motion_phase = out_ch.motion_phase;
      got.smoothed_z   = out_ch.smoothed_z;
      got.rep_event    = out_ch.rep_event;
      n_checked++;
      if (rep_expect_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result total=%0d phase=%0d z=%0d event=%0b", $realtime,
                   got.rep_total, got.motion_phase, got.smoothed_z, got.rep_event);
      end else begin
        want = rep_expect_q.pop_front();
        if (got.rep_total !== want.rep_total || got.motion_phase !== want.motion_phase ||
            got.smoothed_z !== want.smoothed_z || got.rep_event !== want.rep_event) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch exp total=%0d phase=%0d z=%0d event=%0b, got %0d %0d %0d %0b",
                     $realtime, want.rep_total, want.motion_phase, want.smoothed_z,
                     want.rep_event, got.rep_total, got.motion_phase, got.smoothed_z,
                     got.rep_event);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d items pending, %0d results outstanding",
                 $realtime, tick_q.size(), rep_expect_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic queue_tick(input logic hs, input logic signed [SB-1:0] az,
                            input logic [31:0] now, input logic en, input logic clr);
    tick_t t;
    while (tick_q.size() >= PENDING_MAX) @(negedge clk);
    t.has_sample   = hs;
    t.accel_z      = az;
    t.now_ms       = now;
    t.count_enable = en;
    t.clear_count  = clr;
    tick_q.push_back(t);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || tick_busy || rep_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    drv_cfg_valid <= 1'b1;
    drv_cfg_index <= idx;
    drv_cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_IDX_MODE: cur_mode = val[1:0];
      CFG_IDX_REFR: min_gap_ms = val;
      default: ;
    endcase
    @(negedge clk);
    drv_cfg_valid <= 1'b0;
  endtask

  // Random motion: runs of strong up or down swings, hovering near the
  // thresholds, and some noise; time mostly creeps, sometimes jumps or wraps
  task automatic gen_segment(input int n);
    int                   r;
    int                   gap;
    logic signed [SB-1:0] az;
    for (int i = 0; i < n; i++) begin
      if (lvl_run == 0) begin
        r = $urandom_range(0, 99);
        lvl = r < 35 ? LV_HIGH : r < 70 ? LV_LOW : r < 90 ? LV_HOVER : LV_NOISE;
        lvl_run = $urandom_range(1, 6);
      end
      lvl_run--;
      case (lvl)
        LV_HIGH:  az = SB'($urandom_range(16000, 32767));
        LV_LOW:   az = SB'(-int'($urandom_range(16000, 32768)));
        LV_HOVER: az = SB'(FILT_RESET - 1400 + int'($urandom_range(0, 2800)));
        default:  az = SB'($urandom);
      endcase
      gap = int'(min_gap_ms);
      r = $urandom_range(0, 99);
      if (r < 60)      t_clock += 32'($urandom_range(0, gap / 3 + 2));
      else if (r < 85) t_clock += 32'($urandom_range(gap / 2, gap + 50));
      else if (r < 92) t_clock = t_clock;
      else if (r < 97) t_clock = $urandom;
      else             t_clock = 32'hFFFF_FFFF - 32'($urandom_range(0, 2 * gap + 100));
      queue_tick($urandom_range(0, 99) < 88, az, t_clock,
                 $urandom_range(0, 99) < 92, $urandom_range(0, 99) < 3);
    end
  endtask

  initial begin
    logic [1:0]  seg_mode[4];
    logic [15:0] gap_val;
    seg_mode = '{MODE_PRESS, MODE_CURL, MODE_PULLDOWN, MODE_UNUSED};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: press with the refractory gap at its reset value
    queue_tick(1'b0, AZ_MAX, 32'd0, 1'b1, 1'b0);       // no sample, accel ignored
    queue_tick(1'b1, AZ_MIN, 32'd100, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'd200, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'd300, 1'b1, 1'b0);
    queue_tick(1'b0, '0, 32'd800, 1'b1, 1'b0);         // gap equal, not exceeded
    queue_tick(1'b0, '0, 32'd801, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MIN, 32'd900, 1'b0, 1'b0);     // counting off
    queue_tick(1'b1, AZ_MIN, 32'd1000, 1'b1, 1'b0);
    queue_tick(1'b1, '0, 32'd1100, 1'b1, 1'b1);        // clear alongside a sample
    queue_tick(1'b1, AZ_MIN, 32'hFFFF_FF00, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'hFFFF_FF40, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'hFFFF_FF80, 1'b1, 1'b0);
    queue_tick(1'b0, '0, 32'hFFFF_FFC0, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MIN, 32'hFFFF_FFD0, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'hFFFF_FFE0, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'hFFFF_FFF0, 1'b1, 1'b0);
    queue_tick(1'b0, '0, 32'h0000_0100, 1'b1, 1'b0);   // wrapped, still too soon
    queue_tick(1'b0, '0, 32'h0000_0300, 1'b1, 1'b0);   // wrapped, gap passed
    queue_tick(1'b1, AZ_MIN, 32'h0000_0400, 1'b1, 1'b0);
    // Curl entered while in down: stuck there until cleared
    wait_drained();
    write_reg(CFG_IDX_MODE, {{(CFG_DATA_W-2){1'b0}}, MODE_CURL});
    queue_tick(1'b1, AZ_MAX, 32'h0000_0800, 1'b1, 1'b0);
    queue_tick(1'b0, '0, 32'h0000_0900, 1'b1, 1'b1);
    queue_tick(1'b1, AZ_MAX, 32'h0000_0A00, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MIN, 32'h0000_0B00, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MIN, 32'h0000_1000, 1'b1, 1'b0);
    // Pulldown with no gap: a repeat at the same millisecond is held back
    wait_drained();
    write_reg(CFG_IDX_MODE, {{(CFG_DATA_W-2){1'b1}}, MODE_PULLDOWN});
    write_reg(CFG_IDX_REFR, 16'd0);
    queue_tick(1'b1, AZ_MIN, 32'h0000_1000, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'h0000_1000, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'h0000_1000, 1'b1, 1'b0);
    queue_tick(1'b0, '0, 32'h0000_1001, 1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_IDX_MODE, {{(CFG_DATA_W-2){1'b0}}, MODE_UNUSED});
    write_reg(CFG_IDX_REFR, 16'hFFFF);
    queue_tick(1'b1, AZ_MIN, 32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MAX, 32'h0000_0000, 1'b1, 1'b0);

    // Random motion, cycling through the idle patterns
    for (int seg = 0; seg < N_SEGS; seg++) begin
      wait_drained();
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      case (seg)
        0: gap_val = 16'd0;
        1: gap_val = 16'hFFFF;
        2: gap_val = REFR_RESET;
        3: gap_val = 16'($urandom);
        default: gap_val = 16'($urandom_range(0, 2000));
      endcase
      write_reg(CFG_IDX_REFR, gap_val);
      write_reg(CFG_IDX_MODE, {(CFG_DATA_W-2)'($urandom),
                               seg < 4 ? seg_mode[seg] : 2'($urandom_range(0, 3))});
      gen_segment(TICKS_PER_SEG);
    end

    // Curl with no gap: a few full repetitions, two strong swings each way
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_IDX_REFR, 16'd0);
    write_reg(CFG_IDX_MODE, {{(CFG_DATA_W-2){1'b0}}, MODE_CURL});
    queue_tick(1'b0, '0, t_clock, 1'b0, 1'b1);
    for (int rep = 0; rep < TAIL_REPS; rep++) begin
      queue_tick(1'b1, AZ_MAX, ++t_clock, 1'b1, 1'b0);
      queue_tick(1'b1, AZ_MAX, ++t_clock, 1'b1, 1'b0);
      queue_tick(1'b1, AZ_MIN, ++t_clock, 1'b1, 1'b0);
      queue_tick(1'b1, AZ_MIN, ++t_clock, 1'b1, 1'b0);
    end
    queue_tick(1'b1, AZ_MAX, ++t_clock, 1'b1, 1'b1);
    queue_tick(1'b1, AZ_MAX, ++t_clock, 1'b1, 1'b0);
    queue_tick(1'b1, AZ_MIN, ++t_clock, 1'b1, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    errors += rep_expect_q.size();
    $display("Checked %0d ticks across press, curl, pulldown and the unused mode,", n_checked);
    $display("%0d repetitions recognised under varied idle and stall patterns, %0d errors.",
             n_events, errors);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/acc_rep_pkg.sv
rtl/acc_rep_if.sv
rtl/acc_rep_filter.sv
rtl/acc_rep_phase.sv
rtl/accel_repetition_counter.sv
tb/tb_top.sv
